[sv/capped_floored_swap_leg_npv_top_macros.svh]
// Assertion helpers for the swap leg valuation block.
`ifndef CAPPED_FLOORED_SWAP_LEG_NPV_TOP_MACROS_SVH
`define CAPPED_FLOORED_SWAP_LEG_NPV_TOP_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define CFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/capfl_pkg.sv]
package capfl_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_RND1,
        ST_CLAMP,
        ST_MUL2,
        ST_RND2,
        ST_LD3,
        ST_MUL3,
        ST_RND3,
        ST_LD4,
        ST_MUL4,
        ST_DIV,
        ST_ACC,
        ST_EMIT
    } t_state;

    localparam logic [1:0] CFG_VAL_INDEX = 2'd0;
    localparam logic [1:0] CFG_VAL_NUMER = 2'd1;

    // Half an LSB of a Q24.24 product for round to nearest.
    localparam logic [127:0] ROUND_HALF = 128'h800000;

endpackage

[sv/capped_floored_swap_leg_npv_top.sv]
// Values the coupons of a capped/floored swap on one simulated path. Each accepted item is
// one coupon; a coupon paid after the valuation index with a nonzero payment numeraire is
// priced with four shift-and-add multiplications (one multiplier bit per cycle in a shared
// serial unit) and a restoring division by the payment numeraire (one quotient bit per
// cycle); any other coupon is skipped. The block takes no new coupon until it is through
// with the current one. A last coupon waits longer when the previous result has not yet
// been taken. The item flagged last_coupon delivers one result with both leg sums and
// their difference and clears the sums; the result register holds it while the next path
// starts. Configuration writes take effect at once and are meant for idle periods.
`include "capped_floored_swap_leg_npv_top_macros.svh"

module capped_floored_swap_leg_npv_top #(
    parameter int TENOR_POINTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_leg_select,
    input  logic signed [47:0] i_rate_value,
    input  logic signed [47:0] i_nominal,
    input  logic [46:0]        i_accrual_period,
    input  logic signed [47:0] i_rate_multiplier,
    input  logic signed [47:0] i_rate_spread,
    input  logic [1:0]         i_clamp_mode,
    input  logic signed [47:0] i_cap_strike,
    input  logic signed [47:0] i_floor_strike,
    input  logic [7:0]         i_payment_index,
    input  logic [47:0]        i_payment_numeraire,
    input  logic               i_last_coupon,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_first_leg_value,
    output logic signed [63:0] o_second_leg_value,
    output logic signed [63:0] o_swap_value
);

    localparam int IW = ($clog2(TENOR_POINTS) > 8) ? $clog2(TENOR_POINTS) + 1 : 9;

    function automatic logic [63:0] f_mag(input logic signed [63:0] x);
        return x[63] ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

    function automatic logic signed [63:0] f_from_mag(input logic neg, input logic [63:0] m,
                                                      input logic over);
        logic signed [63:0] res;
        if (!neg) begin
            res = (over || m[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m);
        end else begin
            res = (over || m[63]) ? 64'sh8000_0000_0000_0000 : $signed(64'd0 - m);
        end
        return res;
    endfunction

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] s;
        logic signed [63:0] res;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            res = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            res = s;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] f_ssub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] s;
        logic signed [63:0] res;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            res = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            res = s;
        end
        return res;
    endfunction

    function automatic logic [IW-1:0] f_clamp_idx(input logic [7:0] idx);
        logic [IW-1:0] x;
        x = IW'(idx);
        return (x >= IW'(TENOR_POINTS)) ? IW'(TENOR_POINTS - 1) : x;
    endfunction

    capfl_pkg::t_state r_state;
    capfl_pkg::t_state n_state;

    logic [7:0]         r_val_idx;
    logic [47:0]        r_val_num;
    logic signed [63:0] r_sum1;
    logic signed [63:0] r_sum2;

    logic               r_leg;
    logic               r_last;
    logic signed [47:0] r_nominal;
    logic [46:0]        r_period;
    logic signed [47:0] r_spread;
    logic [1:0]         r_mode;
    logic signed [47:0] r_cap;
    logic signed [47:0] r_flr;
    logic [47:0]        r_pn;

    logic [63:0]        r_ma;
    logic [63:0]        r_mb;
    logic [63:0]        r_hi;
    logic [63:0]        r_lo;
    logic               r_neg;
    logic [47:0]        r_rem;
    logic [6:0]         r_cnt;
    logic signed [63:0] r_t;
    logic signed [63:0] r_c;

    logic               r_ovld;
    logic signed [63:0] r_o1;
    logic signed [63:0] r_o2;
    logic signed [63:0] r_o3;

    logic               w_skip;
    logic               w_accept;
    logic               w_slot_free;
    logic               w_mul_done;
    logic               w_div_done;
    logic [64:0]        w_mul_sum;
    logic [48:0]        w_div_shift;
    logic               w_div_ge;
    logic [127:0]       w_rnd;
    logic signed [63:0] w_mulq;
    logic signed [63:0] w_coupon;
    logic signed [63:0] w_pv;
    logic signed [63:0] w_nom64;
    logic signed [63:0] w_mult64;
    logic signed [63:0] w_rate64;

    assign w_skip = (f_clamp_idx(i_payment_index) <= f_clamp_idx(r_val_idx))
                  || (i_payment_numeraire == 48'd0);
    assign w_accept   = i_valid && o_ready;
    assign w_mul_done = (r_cnt[5:0] == 6'h3F);
    assign w_div_done = (r_cnt == 7'h7F);

    assign w_nom64  = 64'(r_nominal);
    assign w_mult64 = 64'(i_rate_multiplier);
    assign w_rate64 = 64'(i_rate_value);

    assign w_mul_sum   = {1'b0, r_hi} + (r_mb[0] ? {1'b0, r_ma} : 65'd0);
    assign w_div_shift = {r_rem, r_hi[63]};
    assign w_div_ge    = (w_div_shift >= {1'b0, r_pn});

    assign w_rnd  = {r_hi, r_lo} + capfl_pkg::ROUND_HALF;
    assign w_mulq = f_from_mag(r_neg, w_rnd[87:24], |w_rnd[127:88]);
    assign w_pv   = f_from_mag(r_neg, r_lo, |r_hi);

    // Cap first, then floor, on the saturated coupon rate.
    always_comb begin
        w_coupon = f_sadd(r_t, 64'(r_spread));
        if (r_mode[0] && (64'(r_cap) < w_coupon)) begin
            w_coupon = 64'(r_cap);
        end
        if (r_mode[1] && (64'(r_flr) > w_coupon)) begin
            w_coupon = 64'(r_flr);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            capfl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_skip) begin
                        n_state = i_last_coupon ? capfl_pkg::ST_EMIT : capfl_pkg::ST_IDLE;
                    end else begin
                        n_state = capfl_pkg::ST_MUL1;
                    end
                end
            end
            capfl_pkg::ST_MUL1:  if (w_mul_done) n_state = capfl_pkg::ST_RND1;
            capfl_pkg::ST_RND1:  n_state = capfl_pkg::ST_CLAMP;
            capfl_pkg::ST_CLAMP: n_state = capfl_pkg::ST_MUL2;
            capfl_pkg::ST_MUL2:  if (w_mul_done) n_state = capfl_pkg::ST_RND2;
            capfl_pkg::ST_RND2:  n_state = capfl_pkg::ST_LD3;
            capfl_pkg::ST_LD3:   n_state = capfl_pkg::ST_MUL3;
            capfl_pkg::ST_MUL3:  if (w_mul_done) n_state = capfl_pkg::ST_RND3;
            capfl_pkg::ST_RND3:  n_state = capfl_pkg::ST_LD4;
            capfl_pkg::ST_LD4:   n_state = capfl_pkg::ST_MUL4;
            capfl_pkg::ST_MUL4:  if (w_mul_done) n_state = capfl_pkg::ST_DIV;
            capfl_pkg::ST_DIV:   if (w_div_done) n_state = capfl_pkg::ST_ACC;
            capfl_pkg::ST_ACC: begin
                n_state = r_last ? capfl_pkg::ST_EMIT : capfl_pkg::ST_IDLE;
            end
            capfl_pkg::ST_EMIT:  if (w_slot_free) n_state = capfl_pkg::ST_IDLE;
            default:             n_state = capfl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == capfl_pkg::ST_IDLE);
        w_slot_free = !r_ovld || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= capfl_pkg::ST_IDLE;
            r_val_idx <= 8'd0;
            r_val_num <= 48'd16777216;
            r_sum1    <= '0;
            r_sum2    <= '0;
            r_ovld    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_index == capfl_pkg::CFG_VAL_INDEX) begin
                    r_val_idx <= i_cfg_data[7:0];
                end else if (i_cfg_index == capfl_pkg::CFG_VAL_NUMER) begin
                    r_val_num <= i_cfg_data;
                end
            end

            if (r_state == capfl_pkg::ST_MUL1 || r_state == capfl_pkg::ST_MUL2
                || r_state == capfl_pkg::ST_MUL3 || r_state == capfl_pkg::ST_DIV
                || (r_state == capfl_pkg::ST_MUL4 && !w_mul_done)) begin
                r_cnt <= r_cnt + 7'd1;
            end else begin
                r_cnt <= '0;
            end

            if (r_state == capfl_pkg::ST_EMIT && w_slot_free) begin
                r_ovld <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovld <= 1'b0;
            end

            if (r_state == capfl_pkg::ST_ACC) begin
                if (r_leg) begin
                    r_sum2 <= f_sadd(r_sum2, w_pv);
                end else begin
                    r_sum1 <= f_sadd(r_sum1, w_pv);
                end
            end

            if (r_state == capfl_pkg::ST_EMIT && w_slot_free) begin
                r_sum1 <= '0;
                r_sum2 <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == capfl_pkg::ST_EMIT && w_slot_free) begin
            r_o1 <= r_sum1;
            r_o2 <= r_sum2;
            r_o3 <= f_ssub(r_sum1, r_sum2);
        end

        unique case (r_state)
            capfl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_leg     <= i_leg_select;
                    r_last    <= i_last_coupon;
                    r_nominal <= i_nominal;
                    r_period  <= i_accrual_period;
                    r_spread  <= i_rate_spread;
                    r_mode    <= i_clamp_mode;
                    r_cap     <= i_cap_strike;
                    r_flr     <= i_floor_strike;
                    r_pn      <= i_payment_numeraire;
                    r_ma      <= f_mag(w_mult64);
                    r_mb      <= f_mag(w_rate64);
                    r_neg     <= i_rate_multiplier[47] ^ i_rate_value[47];
                    r_hi      <= '0;
                    r_lo      <= '0;
                end
            end
            capfl_pkg::ST_MUL1, capfl_pkg::ST_MUL2,
            capfl_pkg::ST_MUL3, capfl_pkg::ST_MUL4: begin
                r_hi <= w_mul_sum[64:1];
                r_lo <= {w_mul_sum[0], r_lo[63:1]};
                r_mb <= {1'b0, r_mb[63:1]};
            end
            capfl_pkg::ST_RND1, capfl_pkg::ST_RND2, capfl_pkg::ST_RND3: begin
                r_t <= w_mulq;
            end
            capfl_pkg::ST_CLAMP: begin
                r_c   <= w_coupon;
                r_ma  <= f_mag(w_nom64);
                r_mb  <= {17'd0, r_period};
                r_neg <= r_nominal[47];
                r_hi  <= '0;
                r_lo  <= '0;
            end
            capfl_pkg::ST_LD3: begin
                r_ma  <= f_mag(r_t);
                r_mb  <= f_mag(r_c);
                r_neg <= r_t[63] ^ r_c[63];
                r_hi  <= '0;
                r_lo  <= '0;
            end
            capfl_pkg::ST_LD4: begin
                r_ma  <= f_mag(r_t);
                r_mb  <= {16'd0, r_val_num};
                r_neg <= r_t[63];
                r_hi  <= '0;
                r_lo  <= '0;
                r_rem <= '0;
            end
            capfl_pkg::ST_DIV: begin
                // The dividend leaves at the top while quotient bits fill in at the bottom.
                r_rem <= w_div_ge ? 48'(w_div_shift - {1'b0, r_pn}) : w_div_shift[47:0];
                r_hi  <= {r_hi[62:0], r_lo[63]};
                r_lo  <= {r_lo[62:0], w_div_ge};
            end
            capfl_pkg::ST_ACC, capfl_pkg::ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_valid            = r_ovld;
    assign o_first_leg_value  = r_o1;
    assign o_second_leg_value = r_o2;
    assign o_swap_value       = r_o3;

    `CFS_ASSERT_NEXT(a_busy_after_accept, w_accept && !w_skip, !o_ready, "ready while pricing")
    `CFS_ASSERT_NOW(a_rem_below_divisor, r_state == capfl_pkg::ST_DIV, r_rem < r_pn, "remainder not below divisor")
    `CFS_ASSERT_NEXT(a_sums_cleared, (r_state == capfl_pkg::ST_EMIT) && w_slot_free, (r_sum1 == 64'sd0) && (r_sum2 == 64'sd0) && o_valid, "sums not cleared after result")

endmodule

[bench/capped_floored_swap_leg_npv_top_tb.sv]
`timescale 1ns / 1ps

module capped_floored_swap_leg_npv_top_tb;

    localparam int TENOR = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 500;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

    typedef struct packed {
        logic               leg;
        logic signed [47:0] rate;
        logic signed [47:0] nominal;
        logic [46:0]        period;
        logic signed [47:0] mult;
        logic signed [47:0] spread;
        logic [1:0]         mode;
        logic signed [47:0] cap;
        logic signed [47:0] flr;
        logic [7:0]         pay_idx;
        logic [47:0]        pay_num;
        logic               last;
    } t_coupon;

    typedef struct packed {
        logic signed [63:0] first_leg;
        logic signed [63:0] second_leg;
        logic signed [63:0] swap;
    } t_npv;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [47:0] i_cfg_data;
    logic i_valid, o_ready;
    logic i_leg_select;
    logic signed [47:0] i_rate_value, i_nominal, i_rate_multiplier, i_rate_spread;
    logic [46:0] i_accrual_period;
    logic [1:0] i_clamp_mode;
    logic signed [47:0] i_cap_strike, i_floor_strike;
    logic [7:0] i_payment_index;
    logic [47:0] i_payment_numeraire;
    logic i_last_coupon;
    logic o_valid, i_ready;
    logic signed [63:0] o_first_leg_value, o_second_leg_value, o_swap_value;

    capped_floored_swap_leg_npv_top #(.TENOR_POINTS(TENOR)) dut (.*);

    // Predictor state.
    logic [7:0]         val_index;
    logic [47:0]        val_numer;
    logic signed [63:0] first_sum, second_sum;

    t_npv expected_npv[$];
    int   mismatches;
    int   results_seen;
    int   idle_cycles;
    bit   timed_out;
    bit   stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] sat_mag(logic neg, logic [127:0] m);
        if (!neg) return (m > 128'(S64_MAX)) ? S64_MAX : 64'(m);
        if (m >= 128'h8000000000000000) return S64_MIN;
        return -$signed(64'(m));
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S64_MAX)) return S64_MAX;
        if (s < 65'(S64_MIN)) return S64_MIN;
        return 64'(s);
    endfunction

    function automatic logic signed [63:0] sub_sat(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'(S64_MAX)) return S64_MAX;
        if (s < 65'(S64_MIN)) return S64_MIN;
        return 64'(s);
    endfunction

    // Q24.24 product, magnitude rounded half away from zero, then saturated.
    function automatic logic signed [63:0] q_mul(logic signed [63:0] a,
                                                 logic signed [63:0] b);
        logic [127:0] p;
        p = 128'(abs64(a)) * 128'(abs64(b)) + 128'h800000;
        return sat_mag((a < 0) != (b < 0), p >> 24);
    endfunction

    function automatic logic signed [63:0] discount(logic signed [63:0] flow,
                                                    logic [47:0] pn);
        logic [127:0] p;
        p = 128'(abs64(flow)) * 128'(val_numer);
        return sat_mag(flow < 0, p / 128'(pn));
    endfunction

    function automatic logic [7:0] clamp_idx(logic [7:0] i);
        return (int'(i) >= TENOR) ? 8'(TENOR - 1) : i;
    endfunction

    task automatic price_coupon(t_coupon c);
        logic signed [63:0] rate, flow, pv;
        t_npv r;
        if (clamp_idx(c.pay_idx) > clamp_idx(val_index) && c.pay_num != 0) begin
            rate = add_sat(q_mul(64'(c.mult), 64'(c.rate)), 64'(c.spread));
            if (c.mode[0] && 64'(c.cap) < rate) rate = 64'(c.cap);
            if (c.mode[1] && 64'(c.flr) > rate) rate = 64'(c.flr);
            flow = q_mul(q_mul(64'(c.nominal), $signed({17'd0, c.period})), rate);
            pv = discount(flow, c.pay_num);
            if (c.leg == 1'b0) first_sum = add_sat(first_sum, pv);
            else second_sum = add_sat(second_sum, pv);
        end
        if (c.last) begin
            r.first_leg = first_sum;
            r.second_leg = second_sum;
            r.swap = sub_sat(first_sum, second_sum);
            expected_npv.push_back(r);
            first_sum = '0;
            second_sum = '0;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Valid stays high into the next item when there is no gap; the next payload
    // replaces the accepted one at the same edge.
    task automatic send_coupon(t_coupon c);
        int gap;
        gap = stall_enable ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_leg_select <= c.leg;
        i_rate_value <= c.rate;
        i_nominal <= c.nominal;
        i_accrual_period <= c.period;
        i_rate_multiplier <= c.mult;
        i_rate_spread <= c.spread;
        i_clamp_mode <= c.mode;
        i_cap_strike <= c.cap;
        i_floor_strike <= c.flr;
        i_payment_index <= c.pay_idx;
        i_payment_numeraire <= c.pay_num;
        i_last_coupon <= c.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        price_coupon(c);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == capfl_pkg::CFG_VAL_INDEX) val_index = value[7:0];
        else if (idx == capfl_pkg::CFG_VAL_NUMER) val_numer = value;
        @(posedge i_clk);
    endtask

    // Skipped coupons produce no result, so allow the engine to finish before a write.
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (expected_npv.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic signed [47:0] rand_q(int int_bits);
        logic signed [47:0] v;
        v = 48'($signed({$urandom(), $urandom()}) >>> (48 - 24 - int_bits));
        return v;
    endfunction

    function automatic t_coupon rand_coupon(bit wild);
        t_coupon c;
        c.leg = 1'($urandom_range(0, 1));
        c.mode = 2'($urandom_range(0, 3));
        c.last = ($urandom_range(0, 7) == 0);
        c.pay_idx = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                    : 8'(int'(val_index) + $urandom_range(0, 20));
        if (wild) begin
            c.rate = rand48();
            c.nominal = rand48();
            c.period = 47'({$urandom(), $urandom()});
            c.mult = rand48();
            c.spread = rand48();
            c.cap = rand48();
            c.flr = rand48();
            c.pay_num = 48'({$urandom(), $urandom()});
        end else begin
            c.rate = rand_q(0);
            c.nominal = rand_q(12);
            c.period = 47'($urandom_range(0, 1 << 25));
            c.mult = rand_q(2);
            c.spread = rand_q(0);
            c.cap = rand_q(0);
            c.flr = rand_q(0);
            c.pay_num = 48'($urandom_range(1 << 22, 1 << 26));
        end
        return c;
    endfunction

    initial begin
        t_npv got, want;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = '{o_first_leg_value, o_second_leg_value, o_swap_value};
                results_seen++;
                if (expected_npv.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h", got);
                end else begin
                    want = expected_npv.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: first %h/%h second %h/%h swap %h/%h",
                                     want.first_leg, got.first_leg, want.second_leg,
                                     got.second_leg, want.swap, got.swap);
                    end
                end
            end
            i_ready <= stall_enable ? (pick_gap() == 0) : 1'b1;
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)
                || (expected_npv.size() == 0 && !i_valid))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                $display("Watchdog expired with %0d results pending", expected_npv.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed();
        t_coupon c;
        c = '{leg: 0, rate: 48'sh0000_0100_0000, nominal: 48'sh0064_0000_0000,
              period: 47'h80_0000, mult: 48'sh0000_0100_0000, spread: 48'sh0,
              mode: 2'd0, cap: 48'sh0, flr: 48'sh0, pay_idx: 8'd1,
              pay_num: 48'h100_0000, last: 1'b0};
        send_coupon(c);
        c.leg = 1'b1; c.mode = 2'd1; c.cap = 48'sh0000_0080_0000;
        send_coupon(c);
        c.mode = 2'd2; c.flr = 48'sh0000_0200_0000;
        send_coupon(c);
        c.mode = 2'd3; c.cap = -48'sh100_0000; c.flr = 48'sh100_0000;
        send_coupon(c);
        // Zero payment numeraire contributes nothing.
        c.pay_num = '0;
        send_coupon(c);
        c.pay_num = 48'hFFFF_FFFF_FFFF; c.leg = 1'b0;
        send_coupon(c);
        // Extremes of every field; saturation in every stage.
        c = '{leg: 0, rate: 48'sh7FFF_FFFF_FFFF, nominal: 48'sh7FFF_FFFF_FFFF,
              period: 47'h7FFF_FFFF_FFFF, mult: 48'sh7FFF_FFFF_FFFF,
              spread: 48'sh7FFF_FFFF_FFFF, mode: 2'd0, cap: 48'sh7FFF_FFFF_FFFF,
              flr: 48'sh8000_0000_0000, pay_idx: 8'd255, pay_num: 48'h1, last: 1'b0};
        send_coupon(c);
        send_coupon(c);
        c.leg = 1'b1; c.nominal = 48'sh8000_0000_0000; c.mult = 48'sh8000_0000_0000;
        c.spread = 48'sh8000_0000_0000;
        send_coupon(c);
        c.last = 1'b1;
        send_coupon(c);
        // Skipped last coupon still emits and clears.
        c.pay_idx = 8'd0; c.leg = 1'b0;
        send_coupon(c);
        c.pay_idx = 8'd3; c.last = 1'b0; c.rate = 48'sh0;
        send_coupon(c);
        c.last = 1'b1; c.pay_idx = 8'd0;
        send_coupon(c);
        wait_quiet();
    endtask

    task automatic test_config_settings();
        t_coupon c;
        // Zero valuation numeraire zeroes every coupon.
        write_reg(capfl_pkg::CFG_VAL_NUMER, 48'h0);
        c = rand_coupon(1'b0); c.pay_idx = 8'd5; c.last = 1'b1;
        send_coupon(c);
        wait_quiet();
        write_reg(capfl_pkg::CFG_VAL_NUMER, 48'hFFFF_FFFF_FFFF);
        write_reg(capfl_pkg::CFG_VAL_INDEX, 48'd255);
        c.pay_idx = 8'd255;
        send_coupon(c);
        wait_quiet();
        write_reg(capfl_pkg::CFG_VAL_INDEX, 48'd254);
        c.pay_idx = 8'd255; c.last = 1'b0;
        send_coupon(c);
        c.last = 1'b1; c.leg = ~c.leg;
        send_coupon(c);
        wait_quiet();
        // Writes to unused indexes must leave the registers alone.
        write_reg(2'd2, 48'h0);
        write_reg(2'd3, 48'h0);
        write_reg(capfl_pkg::CFG_VAL_INDEX, 48'd0);
        write_reg(capfl_pkg::CFG_VAL_NUMER, 48'h100_0000);
    endtask

    task automatic test_random_paths();
        t_coupon c;
        int phase, k;
        for (phase = 0; phase < 6; phase++) begin
            wait_quiet();
            write_reg(capfl_pkg::CFG_VAL_INDEX, 48'($urandom_range(0, 200)));
            write_reg(capfl_pkg::CFG_VAL_NUMER, phase == 0 ? 48'h1 :
                      48'($urandom_range(1 << 22, 1 << 26)) | {$urandom(), 16'h0} & {48{phase == 5}});
            for (k = 0; k < 320; k++) begin
                c = rand_coupon($urandom_range(0, 9) == 0);
                if (k == 319) c.last = 1'b1;
                send_coupon(c);
            end
        end
        wait_quiet();
    endtask

    initial begin
        int cycles;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_leg_select = 1'b0; i_rate_value = '0; i_nominal = '0;
        i_accrual_period = '0; i_rate_multiplier = '0; i_rate_spread = '0;
        i_clamp_mode = '0; i_cap_strike = '0; i_floor_strike = '0;
        i_payment_index = '0; i_payment_numeraire = '0; i_last_coupon = 1'b0;
        val_index = '0; val_numer = 48'h100_0000;
        first_sum = '0; second_sum = '0;
        mismatches = 0; results_seen = 0; timed_out = 1'b0; stall_enable = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        stall_enable = 1'b1;
        test_config_settings();
        test_random_paths();
        cycles = 0;
        while (expected_npv.size() != 0 && cycles < 100000) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += expected_npv.size();
        $display("Covered directed extremes, register settings and random paths;");
        $display("%0d swap results checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

[capped_floored_swap_leg_npv_top.f]
+incdir+sv
sv/capfl_pkg.sv
sv/capped_floored_swap_leg_npv_top.sv
bench/capped_floored_swap_leg_npv_top_tb.sv
